>>> rtl/core/rmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared sizes, types and channel arithmetic for the RGB565 mip chain builder.
// ----------------------------------------------------------------------------
package rmc_pkg;

	localparam int BASE_SIZE = 128;
	localparam int LEVELS    = 4;

	localparam int CNT_W   = $clog2(BASE_SIZE);
	localparam int ADDR_W  = CNT_W;
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int PIX_W   = 16;
	localparam int PSUM_W  = 19;
	localparam int COORD_W = 7;
	localparam int OLVL_W  = 2;

	// smallest level: side length and the shift that divides its sums by its pixel count
	localparam int LAST_SIZE = ((BASE_SIZE >> (LEVELS - 1)) > 0) ?
		(BASE_SIZE >> (LEVELS - 1)) : 1;
	localparam int MEAN_SH   = 2 * $clog2(LAST_SIZE);
	localparam int RED_TW    = 5 + MEAN_SH;
	localparam int GRN_TW    = 6 + MEAN_SH;
	localparam int BLU_TW    = 5 + MEAN_SH;

	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [PSUM_W-1:0]  psum_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [OLVL_W-1:0]  olvl_t;

	localparam lvl_t LAST_LVL   = lvl_t'(LEVELS - 1);
	localparam lvl_t ENTRY_FULL = lvl_t'(0);
	localparam lvl_t ENTRY_HALF = lvl_t'(1);

	typedef struct packed {
		olvl_t  level;
		coord_t col;
		coord_t row;
		pix_t   pix;
		logic   is_mean;
		logic   last;
	} res_t;

	typedef struct packed {
		logic add;
		logic clr;
		pix_t pix;
	} mean_ctl_t;

	// largest column/row index of a level
	function automatic cnt_t lvl_last(lvl_t l);
		int s;
		s = BASE_SIZE >> l;
		if (s < 1) begin
			s = 1;
		end
		return cnt_t'(s - 1);
	endfunction

	// first line-buffer entry of the pair sums that feed level l+1
	function automatic addr_t region_base(lvl_t l);
		return addr_t'(BASE_SIZE - (BASE_SIZE >> l));
	endfunction

	// horizontal pair sum: red 18-13, green 12-6, blue 5-0
	function automatic psum_t pair_sum(pix_t a, pix_t b);
		logic [5:0] r;
		logic [6:0] g;
		logic [5:0] bl;
		r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
		g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
		bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
		return {r, g, bl};
	endfunction

	// 2x2 average from the pair sums of two rows, truncated
	function automatic pix_t quad_avg(psum_t s1, psum_t s2);
		logic [6:0] r;
		logic [7:0] g;
		logic [6:0] bl;
		r  = {1'b0, s1[18:13]} + {1'b0, s2[18:13]};
		g  = {1'b0, s1[12:6]}  + {1'b0, s2[12:6]};
		bl = {1'b0, s1[5:0]}   + {1'b0, s2[5:0]};
		return {r[6:2], g[7:2], bl[6:2]};
	endfunction

endpackage

>>> rtl/core/rgb565_mip_chain_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_mip_chain_builder
// Builds the 2x2 box-filtered mip chain of an RGB565 texture streamed in
// raster order, plus the mean colour of the smallest level.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on pixel_valid/pixel_ready, one per transfer, raster order.
//   Results leave on result_valid/result_ready with level, col, row,
//   pixel_out, is_mean and last; last marks the final result of a pixel.
//   cfg_wr_en/cfg_wr_data write half_size_input; the user must write it only
//   while the block is idle; the block does not enforce it. Each pixel causes
//   one result for its own level, one more per coarser pixel it completes
//   (one level per cycle through the pair-sum line buffer while the output
//   register has room), one for the mean, and four extra for the doubled
//   level-0 pixels in half-size mode. So 1 to 5 results at full size, 5 to 8
//   at half size; most full-size pixels cause a single result. The next pixel
//   is taken in the cycle the last result of the previous one is written to
//   the output register. A stalled receiver holds the output register and
//   stops the sequencer; no result is lost. Reset clears counters, totals and
//   the mode; the line buffer needs no clearing, every read follows a write
//   of the same entry.
// ----------------------------------------------------------------------------
module rgb565_mip_chain_builder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [15:0]           pixel_in,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [1:0]            level,
	output logic [6:0]            col,
	output logic [6:0]            row,
	output logic [15:0]           pixel_out,
	output logic                  is_mean,
	output logic                  last
);

	logic               slot_free;
	logic               push;
	rmc_pkg::res_t      res;
	rmc_pkg::res_t      res_q;
	rmc_pkg::mean_ctl_t mean_ctl;
	rmc_pkg::pix_t      mean_pix;

	rmc_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_in    (pixel_in),
		.slot_free   (slot_free),
		.push        (push),
		.res         (res),
		.mean_ctl    (mean_ctl),
		.mean_pix    (mean_pix)
	);

	rmc_mean u_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mean_ctl),
		.mean   (mean_pix)
	);

	rmc_obuf u_obuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.res          (res),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.res_q        (res_q)
	);

	assign level     = res_q.level;
	assign col       = res_q.col;
	assign row       = res_q.row;
	assign pixel_out = res_q.pix;
	assign is_mean   = res_q.is_mean;
	assign last      = res_q.last;

endmodule

>>> rtl/core/rmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module rmc_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/rmc_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_mean
// Per-channel totals over the smallest level and its mean colour.
// ----------------------------------------------------------------------------
module rmc_mean (
	input  logic              clk,
	input  logic              arst_n,
	input  rmc_pkg::mean_ctl_t ctl,
	output rmc_pkg::pix_t     mean
);

	logic [rmc_pkg::RED_TW-1:0] red_q;
	logic [rmc_pkg::GRN_TW-1:0] grn_q;
	logic [rmc_pkg::BLU_TW-1:0] blu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= '0;
			grn_q <= '0;
			blu_q <= '0;
		end else if (ctl.clr) begin
			red_q <= '0;
			grn_q <= '0;
			blu_q <= '0;
		end else if (ctl.add) begin
			red_q <= red_q + rmc_pkg::RED_TW'(ctl.pix[15:11]);
			grn_q <= grn_q + rmc_pkg::GRN_TW'(ctl.pix[10:5]);
			blu_q <= blu_q + rmc_pkg::BLU_TW'(ctl.pix[4:0]);
		end
	end

	assign mean = {red_q[rmc_pkg::MEAN_SH +: 5], grn_q[rmc_pkg::MEAN_SH +: 6],
		blu_q[rmc_pkg::MEAN_SH +: 5]};

endmodule

>>> rtl/core/rmc_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_walk
// Per-pixel sequencer, one result per cycle while the output slot is free:
// half-size level-0 doubles, mip levels via the pair-sum line buffer, mean.
// ----------------------------------------------------------------------------
module rmc_walk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  rmc_pkg::pix_t      pixel_in,
	input  logic               slot_free,
	output logic               push,
	output rmc_pkg::res_t      res,
	output rmc_pkg::mean_ctl_t mean_ctl,
	input  rmc_pkg::pix_t      mean_pix
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DBL  = 2'd1;
	localparam logic [1:0] ST_LVL  = 2'd2;
	localparam logic [1:0] ST_MEAN = 2'd3;

	localparam logic [1:0] DBL_LAST = 2'd3;

	logic [1:0]            state_q;
	logic [1:0]            dbl_q;
	rmc_pkg::lvl_t         lvl_q;
	rmc_pkg::pix_t         pix_q;
	logic                  avg_sel_q;
	logic                  half_q;
	rmc_pkg::psum_t        sum_s1;
	rmc_pkg::cnt_t         col_cnt_q [rmc_pkg::LEVELS];
	rmc_pkg::cnt_t         row_cnt_q [rmc_pkg::LEVELS];
	rmc_pkg::pix_t         pend_q    [rmc_pkg::LEVELS];

	logic                  active;
	logic                  fire;
	logic                  done;
	logic                  accept;
	rmc_pkg::cnt_t         cur_c;
	rmc_pkg::cnt_t         cur_r;
	rmc_pkg::cnt_t         half_c;
	rmc_pkg::cnt_t         half_r;
	logic                  c_last;
	logic                  r_last;
	logic                  top_lvl;
	logic                  cascade;
	logic                  to_mean;
	rmc_pkg::pix_t         cur_p;
	rmc_pkg::psum_t        new_sum;
	rmc_pkg::addr_t        addr;
	logic                  ram_we;
	logic                  ram_re;
	rmc_pkg::psum_t        ram_rdata;

	rmc_ram #(
		.WIDTH(rmc_pkg::PSUM_W),
		.DEPTH(rmc_pkg::BASE_SIZE)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (new_sum),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		active  = state_q != ST_IDLE;
		fire    = active && slot_free;
		cur_c   = col_cnt_q[lvl_q];
		cur_r   = row_cnt_q[lvl_q];
		half_c  = col_cnt_q[rmc_pkg::ENTRY_HALF];
		half_r  = row_cnt_q[rmc_pkg::ENTRY_HALF];
		c_last  = cur_c == rmc_pkg::lvl_last(lvl_q);
		r_last  = cur_r == rmc_pkg::lvl_last(lvl_q);
		top_lvl = lvl_q == rmc_pkg::LAST_LVL;
		// a pixel coming up from the level above arrives as its 2x2 average
		cur_p   = avg_sel_q ? rmc_pkg::quad_avg(ram_rdata, sum_s1) : pix_q;
		new_sum = rmc_pkg::pair_sum(pend_q[lvl_q], cur_p);
		addr    = rmc_pkg::region_base(lvl_q) + rmc_pkg::addr_t'(cur_c >> 1);
		cascade = !top_lvl && cur_c[0] && cur_r[0];
		to_mean = top_lvl && c_last && r_last;

		case (state_q)
			ST_DBL:  done = 1'b0;
			ST_LVL:  done = !cascade && !to_mean;
			ST_MEAN: done = 1'b1;
			default: done = 1'b0;
		endcase

		res.is_mean = 1'b0;
		res.last    = done;
		case (state_q)
			ST_DBL: begin
				res.level = '0;
				res.col   = rmc_pkg::coord_t'({half_c, dbl_q[0]});
				res.row   = rmc_pkg::coord_t'({half_r, dbl_q[1]});
				res.pix   = pix_q;
			end
			ST_MEAN: begin
				res.level   = rmc_pkg::olvl_t'(rmc_pkg::LAST_LVL);
				res.col     = '0;
				res.row     = '0;
				res.pix     = mean_pix;
				res.is_mean = 1'b1;
			end
			default: begin
				res.level = rmc_pkg::olvl_t'(lvl_q);
				res.col   = rmc_pkg::coord_t'(cur_c);
				res.row   = rmc_pkg::coord_t'(cur_r);
				res.pix   = cur_p;
			end
		endcase

		push        = fire;
		pixel_ready = !active || (fire && done);
		accept      = pixel_valid && pixel_ready;

		ram_we = fire && (state_q == ST_LVL) && !top_lvl && cur_c[0] && !cur_r[0];
		ram_re = fire && (state_q == ST_LVL) && cascade;

		mean_ctl.add = fire && (state_q == ST_LVL) && top_lvl;
		mean_ctl.clr = fire && (state_q == ST_MEAN);
		mean_ctl.pix = cur_p;
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel_in;
		end
		if (fire && (state_q == ST_LVL)) begin
			if (!top_lvl && !cur_c[0]) begin
				pend_q[lvl_q] <= cur_p;
			end
			if (cascade) begin
				sum_s1 <= new_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dbl_q     <= '0;
			lvl_q     <= '0;
			avg_sel_q <= 1'b0;
			half_q    <= 1'b0;
			for (int i = 0; i < rmc_pkg::LEVELS; i++) begin
				col_cnt_q[i] <= '0;
				row_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				half_q <= cfg_wr_data;
			end
			if (fire) begin
				case (state_q)
					ST_DBL: begin
						dbl_q <= dbl_q + 2'd1;
						if (dbl_q == DBL_LAST) begin
							state_q   <= ST_LVL;
							lvl_q     <= rmc_pkg::ENTRY_HALF;
							avg_sel_q <= 1'b0;
						end
					end
					ST_LVL: begin
						if (c_last) begin
							col_cnt_q[lvl_q] <= '0;
							row_cnt_q[lvl_q] <= r_last ? '0 : cur_r + rmc_pkg::cnt_t'(1);
						end else begin
							col_cnt_q[lvl_q] <= cur_c + rmc_pkg::cnt_t'(1);
						end
						if (cascade) begin
							lvl_q     <= lvl_q + rmc_pkg::lvl_t'(1);
							avg_sel_q <= 1'b1;
						end else if (to_mean) begin
							state_q <= ST_MEAN;
						end
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				avg_sel_q <= 1'b0;
				dbl_q     <= '0;
				if (half_q) begin
					state_q <= ST_DBL;
					lvl_q   <= rmc_pkg::ENTRY_HALF;
				end else begin
					state_q <= ST_LVL;
					lvl_q   <= rmc_pkg::ENTRY_FULL;
				end
			end else if (fire && done) begin
				state_q <= ST_IDLE;
			end
		end
	end

endmodule

>>> rtl/core/rmc_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmc_obuf
// Result output register; frees its slot in the cycle the receiver takes it.
// ----------------------------------------------------------------------------
module rmc_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rmc_pkg::res_t res,
	output logic          slot_free,
	output logic          result_valid,
	input  logic          result_ready,
	output rmc_pkg::res_t res_q
);

	logic valid_q;

	assign slot_free    = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && slot_free) begin
			res_q <= res;
		end
	end

endmodule

>>> tb/sv/rgb565_mip_chain_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_mip_chain_builder_tb
// Streams RGB565 pixels through the mip chain builder under random handshake
// gaps on both channels. A behavioral predictor tracks the per-level
// counters, pair sums and smallest-level totals, and every result transfer is
// compared field by field with the oldest predicted mip pixel. Covers field
// extremes, mode changes mid-texture, a half-size run long enough to cascade
// down to the smallest level, then random streams in both modes.
// ----------------------------------------------------------------------------
module rgb565_mip_chain_builder_tb;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PRINT_CAP   = 100;

	typedef struct {
		int r;
		int g;
		int b;
	} chan_sum_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        pixel_valid;
	logic        pixel_ready;
	logic [15:0] pixel_in;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  level;
	logic [6:0]  col;
	logic [6:0]  row;
	logic [15:0] pixel_out;
	logic        is_mean;
	logic        last;

	// predictor state
	bit             half_mode;
	int             col_pos [rmc_pkg::LEVELS];
	int             row_pos [rmc_pkg::LEVELS];
	rmc_pkg::pix_t  left_pix [rmc_pkg::LEVELS-1];
	chan_sum_t      row_pairs [rmc_pkg::LEVELS-1][rmc_pkg::BASE_SIZE/2];
	int             red_acc;
	int             grn_acc;
	int             blu_acc;
	int             deepest_lvl;

	rmc_pkg::res_t  pending_results[$];
	int             mismatches;
	int             cycles;
	bit             quiet;

	rgb565_mip_chain_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_in     (pixel_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.level        (level),
		.col          (col),
		.row          (row),
		.pixel_out    (pixel_out),
		.is_mean      (is_mean),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic rmc_pkg::res_t mip_result(int lv, int c, int r, rmc_pkg::pix_t p,
		bit m);
		rmc_pkg::res_t e;
		e.level   = rmc_pkg::olvl_t'(lv);
		e.col     = rmc_pkg::coord_t'(c);
		e.row     = rmc_pkg::coord_t'(r);
		e.pix     = p;
		e.is_mean = m;
		e.last    = 1'b0;
		return e;
	endfunction

	// works out every mip pixel (and mean) that one input pixel causes
	function automatic void predict_mip_outputs(rmc_pkg::pix_t p);
		rmc_pkg::res_t step_q[$];
		int            lv;
		int            c;
		int            r;
		int            side;
		bit            more;
		rmc_pkg::pix_t cur;
		chan_sum_t     s;
		chan_sum_t     up;

		cur = p;
		lv  = half_mode ? 1 : 0;
		if (half_mode) begin
			c = col_pos[1];
			r = row_pos[1];
			step_q.push_back(mip_result(0, 2*c,     2*r,     p, 1'b0));
			step_q.push_back(mip_result(0, 2*c + 1, 2*r,     p, 1'b0));
			step_q.push_back(mip_result(0, 2*c,     2*r + 1, p, 1'b0));
			step_q.push_back(mip_result(0, 2*c + 1, 2*r + 1, p, 1'b0));
		end
		more = 1'b1;
		while (more) begin
			more = 1'b0;
			side = rmc_pkg::BASE_SIZE >> lv;
			c    = col_pos[lv];
			r    = row_pos[lv];
			step_q.push_back(mip_result(lv, c, r, cur, 1'b0));
			if (c == side - 1) begin
				col_pos[lv] = 0;
				row_pos[lv] = (r == side - 1) ? 0 : r + 1;
			end else begin
				col_pos[lv] = c + 1;
			end
			if (lv < rmc_pkg::LEVELS - 1) begin
				if (c % 2 == 0) begin
					left_pix[lv] = cur;
				end else begin
					s.r = left_pix[lv][15:11] + cur[15:11];
					s.g = left_pix[lv][10:5] + cur[10:5];
					s.b = left_pix[lv][4:0] + cur[4:0];
					if (r % 2 == 0) begin
						row_pairs[lv][c/2] = s;
					end else begin
						up  = row_pairs[lv][c/2];
						cur = {5'((up.r + s.r) >> 2), 6'((up.g + s.g) >> 2),
							5'((up.b + s.b) >> 2)};
						lv++;
						more = 1'b1;
					end
				end
			end else begin
				red_acc += cur[15:11];
				grn_acc += cur[10:5];
				blu_acc += cur[4:0];
				if (c == side - 1 && r == side - 1) begin
					step_q.push_back(mip_result(lv, 0, 0,
						{5'(red_acc >> rmc_pkg::MEAN_SH), 6'(grn_acc >> rmc_pkg::MEAN_SH),
						5'(blu_acc >> rmc_pkg::MEAN_SH)}, 1'b1));
					red_acc = 0;
					grn_acc = 0;
					blu_acc = 0;
				end
			end
		end
		if (lv > deepest_lvl) begin
			deepest_lvl = lv;
		end
		step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i]) begin
			pending_results.push_back(step_q[i]);
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("mismatch @%0t: %s", $realtime, what);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin
		rmc_pkg::res_t want;
		rmc_pkg::res_t got;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1) begin
			got = '{level, col, row, pixel_out, is_mean, last};
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result L%0d (%0d,%0d) %h",
					got.level, got.col, got.row, got.pix));
			end else begin
				want = pending_results.pop_front();
				if (got.level !== want.level)
					report_mismatch($sformatf("level %0d, want %0d", got.level, want.level));
				if (got.col !== want.col)
					report_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
				if (got.row !== want.row)
					report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
				if (got.pix !== want.pix)
					report_mismatch($sformatf("pixel_out %h, want %h at L%0d (%0d,%0d)",
						got.pix, want.pix, want.level, want.col, want.row));
				if (got.is_mean !== want.is_mean)
					report_mismatch($sformatf("is_mean %b, want %b", got.is_mean, want.is_mean));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %b, want %b", got.last, want.last));
			end
		end
	end

	// receiver: random hold-off before every result transfer
	initial begin
		int hold;
		result_ready = 1'b0;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_pixel(input rmc_pkg::pix_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_in    <= p;
		do @(posedge clk); while (pixel_ready !== 1'b1);
		predict_mip_outputs(p);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_mode(input bit half);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= half;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		half_mode = half;
	endtask

	function automatic rmc_pkg::pix_t random_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return rmc_pkg::pix_t'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		rmc_pkg::pix_t corner[12];
		corner = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8410,
			16'h7BEF, 16'hAAAA, 16'h5555, 16'h0001, 16'h0800, 16'h0020};
		foreach (corner[i]) begin
			send_pixel(corner[i]);
		end
	endtask

	// mode flips keep every counter; input re-enters at the other level
	task automatic test_mode_switch();
		set_mode(1'b1);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h1234);
		send_pixel(16'hEDCB);
		set_mode(1'b0);
		send_pixel(16'hFFFF);
		send_pixel(16'hF81F);
		send_pixel(16'h07E0);
	endtask

	// half-size input until a pixel cascades all the way to the smallest level
	task automatic test_deep_cascade();
		int sent;
		set_mode(1'b1);
		sent = 0;
		while (deepest_lvl < rmc_pkg::LEVELS - 1) begin
			quiet = (sent % 128) >= 32;
			send_pixel(random_pixel());
			sent++;
		end
		quiet = 1'b0;
		repeat (6) send_pixel(random_pixel());
	endtask

	task automatic test_random_streams();
		int burst;
		for (int phase = 0; phase < 4; phase++) begin
			set_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
			quiet = $urandom_range(0, 3) == 0;
			burst = $urandom_range(12, 20);
			for (int i = 0; i < burst; i++) begin
				send_pixel(random_pixel());
				if ($urandom_range(0, 29) == 0)
					drain();
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		pixel_valid = 1'b0;
		pixel_in    = '0;
		quiet       = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extremes();
		test_mode_switch();
		test_deep_cascade();
		test_random_streams();

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rmc_pkg.sv
rtl/core/rmc_ram.sv
rtl/core/rmc_mean.sv
rtl/core/rmc_walk.sv
rtl/core/rmc_obuf.sv
rtl/core/rgb565_mip_chain_builder.sv
tb/sv/rgb565_mip_chain_builder_tb.sv
